@@ rtl/bed_pkg.sv @@
// Shared types, codes and constants for the button event detector.
package bed_pkg;

  localparam int TICK_W   = 10;
  localparam int MS_W     = 16;
  localparam int RC_W     = 8;
  localparam int ANS_W    = 16;
  localparam int QK_W     = 4;
  localparam int FLAG_W   = 6;
  localparam int MUL_A_W  = MS_W + 1;
  localparam int MUL_B_W  = MS_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int HMS_W    = MS_W + TICK_W;
  localparam int CMP_W    = 2 * MS_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 8;

  localparam logic [2:0] REG_PRESS_LEVEL   = 3'd0;
  localparam logic [2:0] REG_TICK_MS       = 3'd1;
  localparam logic [2:0] REG_LONG_MS       = 3'd2;
  localparam logic [2:0] REG_SHOOT_MS      = 3'd3;
  localparam logic [2:0] REG_CLICK_TIMEOUT = 3'd4;

  localparam logic              PRESS_LEVEL_RST   = 1'b1;
  localparam logic [TICK_W-1:0] TICK_MS_RST       = 10'd10;
  localparam logic [MS_W-1:0]   LONG_MS_RST       = 16'd1000;
  localparam logic [MS_W-1:0]   SHOOT_MS_RST      = 16'd200;
  localparam logic [MS_W-1:0]   CLICK_TIMEOUT_RST = 16'd300;

  localparam int EV_PRESSED  = 0;
  localparam int EV_RELEASED = 1;
  localparam int EV_CLICKED  = 2;
  localparam int EV_DOUBLE   = 3;
  localparam int EV_RUN_END  = 4;
  localparam int EV_SHOT     = 5;

  localparam logic [QK_W-1:0] QK_IDLE    = 4'd0;
  localparam logic [QK_W-1:0] QK_PRESS   = 4'd1;
  localparam logic [QK_W-1:0] QK_HELD    = 4'd2;
  localparam logic [QK_W-1:0] QK_RELEASE = 4'd3;
  localparam logic [QK_W-1:0] QK_CLICK   = 4'd4;
  localparam logic [QK_W-1:0] QK_DOUBLE  = 4'd5;
  localparam logic [QK_W-1:0] QK_REPEAT  = 4'd6;
  localparam logic [QK_W-1:0] QK_HOLD_MS = 4'd7;
  localparam logic [QK_W-1:0] QK_SHOT    = 4'd8;

  typedef struct packed {
    logic              press_level;
    logic [TICK_W-1:0] tick_ms;
    logic [MS_W-1:0]   long_ms;
    logic [MS_W-1:0]   shoot_ms;
    logic [MS_W-1:0]   click_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic load_tick;
    logic load_query;
    logic hold_step;
    logic shot_mul;
    logic shot_step;
    logic quiet_step;
    logic run_step;
    logic query_mul;
    logic query_ans;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic held;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/bed_cfg.sv @@
// Configuration register file with its APB-style access port.
module bed_cfg
  import bed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PRESS_LEVEL:   cfg_nxt.press_level      = pwdata[0];
        REG_TICK_MS:       cfg_nxt.tick_ms          = pwdata[TICK_W-1:0];
        REG_LONG_MS:       cfg_nxt.long_ms          = pwdata[MS_W-1:0];
        REG_SHOOT_MS:      cfg_nxt.shoot_ms         = pwdata[MS_W-1:0];
        REG_CLICK_TIMEOUT: cfg_nxt.click_timeout_ms = pwdata[MS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESS_LEVEL:   prdata = DATA_W'(cfg_r.press_level);
      REG_TICK_MS:       prdata = DATA_W'(cfg_r.tick_ms);
      REG_LONG_MS:       prdata = DATA_W'(cfg_r.long_ms);
      REG_SHOOT_MS:      prdata = DATA_W'(cfg_r.shoot_ms);
      REG_CLICK_TIMEOUT: prdata = DATA_W'(cfg_r.click_timeout_ms);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_level      <= PRESS_LEVEL_RST;
      cfg_r.tick_ms          <= TICK_MS_RST;
      cfg_r.long_ms          <= LONG_MS_RST;
      cfg_r.shoot_ms         <= SHOOT_MS_RST;
      cfg_r.click_timeout_ms <= CLICK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/bed_ctrl.sv @@
// Step sequencer for tick and query items.
module bed_ctrl
  import bed_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_query,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HOLD = 4'd1;
  localparam logic [3:0] ST_SMUL = 4'd2;
  localparam logic [3:0] ST_SHOT = 4'd3;
  localparam logic [3:0] ST_RMUL = 4'd4;
  localparam logic [3:0] ST_RUN  = 4'd5;
  localparam logic [3:0] ST_QMUL = 4'd6;
  localparam logic [3:0] ST_QANS = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_query) begin
            cmd.load_query = 1'b1;
            state_nxt      = ST_QMUL;
          end else begin
            cmd.load_tick = 1'b1;
            state_nxt     = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        cmd.hold_step = 1'b1;
        state_nxt     = sts.held ? ST_SMUL : ST_RMUL;
      end
      ST_SMUL: begin
        cmd.shot_mul = 1'b1;
        state_nxt    = ST_SHOT;
      end
      ST_SHOT: begin
        cmd.shot_step = 1'b1;
        state_nxt     = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.quiet_step = 1'b1;
        state_nxt      = ST_RUN;
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_QMUL: begin
        cmd.query_mul = 1'b1;
        state_nxt     = ST_QANS;
      end
      ST_QANS: begin
        cmd.query_ans = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/bed_dp.sv @@
// Button state, counters, shared multiplier, event flags and result register.
module bed_dp
  import bed_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  input  logic [IN_W-1:0]  in_tdata,
  output sts_t             sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ANS_W-1:0] out_tdata
);

  logic              held_r, held_nxt;
  logic              ln_r, ln_nxt;
  logic              lb_r, lb_nxt;
  logic [MS_W-1:0]   hold_r, hold_nxt;
  logic [MS_W-1:0]   shot_r, shot_nxt;
  logic              parity_r, parity_nxt;
  logic [RC_W-1:0]   rc_r, rc_nxt;
  logic [MS_W-1:0]   quiet_r, quiet_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [QK_W-1:0]   kind_r;
  logic [PROD_W-1:0] prod_r;
  logic [HMS_W-1:0]  hms_r;
  logic [ANS_W-1:0]  ans_r, ans_nxt;
  logic              out_valid_r;
  logic [ANS_W-1:0]  out_data_r;

  logic [TICK_W-1:0]  t_eff;
  logic [MS_W-1:0]    sh_eff;
  logic [MS_W-1:0]    hold_inc;
  logic [MS_W-1:0]    quiet_inc;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_en;
  logic               above_long;
  logic [HMS_W-1:0]   diff;
  logic [CMP_W-1:0]   p_hi;
  logic [CMP_W-1:0]   p_lo;
  logic               shot_hit;
  logic               press_seen;
  logic               release_seen;

  assign t_eff     = (cfg.tick_ms == '0) ? TICK_W'(1) : cfg.tick_ms;
  assign sh_eff    = (cfg.shoot_ms == '0) ? MS_W'(1) : cfg.shoot_ms;
  assign hold_inc  = (hold_r == '1) ? hold_r : hold_r + MS_W'(1);
  assign quiet_inc = (quiet_r == '1) ? quiet_r : quiet_r + MS_W'(1);

  assign press_seen   = (ln_r == cfg.press_level) && (ln_r == lb_r);
  assign release_seen = (ln_r != cfg.press_level) && (ln_r == lb_r);

  assign above_long = hms_r > HMS_W'(cfg.long_ms);
  assign diff       = above_long ? hms_r - HMS_W'(cfg.long_ms) : '0;
  assign p_hi       = prod_r[CMP_W-1:0];
  assign p_lo       = p_hi - CMP_W'(sh_eff);
  assign shot_hit   = (CMP_W'(diff) >= p_lo) && (CMP_W'(diff) < p_hi);

  assign mul_en = cmd.hold_step | cmd.shot_mul | cmd.quiet_step | cmd.query_mul;

  always_comb begin
    if (cmd.hold_step) begin
      mul_a = MUL_A_W'(hold_inc);
      mul_b = MUL_B_W'(t_eff);
    end else if (cmd.shot_mul) begin
      mul_a = MUL_A_W'(shot_r);
      mul_b = sh_eff;
    end else if (cmd.quiet_step) begin
      mul_a = MUL_A_W'(quiet_inc) + MUL_A_W'(1);
      mul_b = MUL_B_W'(t_eff);
    end else begin
      mul_a = MUL_A_W'(hold_r);
      mul_b = MUL_B_W'(t_eff);
    end
  end

  always_comb begin
    held_nxt   = held_r;
    ln_nxt     = ln_r;
    lb_nxt     = lb_r;
    hold_nxt   = hold_r;
    shot_nxt   = shot_r;
    parity_nxt = parity_r;
    rc_nxt     = rc_r;
    quiet_nxt  = quiet_r;
    flags_nxt  = flags_r;
    ans_nxt    = ans_r;

    if (cmd.load_tick) begin
      lb_nxt = ln_r;
      ln_nxt = in_tdata[0];
    end

    if (cmd.hold_step) begin
      if (!held_r) begin
        if (press_seen) begin
          hold_nxt              = '0;
          flags_nxt[EV_PRESSED] = 1'b1;
          held_nxt              = 1'b1;
        end
      end else begin
        hold_nxt = hold_inc;
      end
    end

    if (cmd.shot_step) begin
      if (above_long && (shot_r == '0)) begin
        shot_nxt           = MS_W'(1);
        flags_nxt[EV_SHOT] = 1'b1;
      end else if ((shot_r != '0) && shot_hit) begin
        shot_nxt           = (shot_r == '1) ? shot_r : shot_r + MS_W'(1);
        flags_nxt[EV_SHOT] = 1'b1;
      end
      if (release_seen) begin
        hold_nxt               = '0;
        shot_nxt               = '0;
        flags_nxt[EV_SHOT]     = 1'b0;
        flags_nxt[EV_RELEASED] = 1'b1;
        flags_nxt[EV_CLICKED]  = 1'b1;
        if (parity_r) begin
          flags_nxt[EV_DOUBLE] = 1'b1;
          parity_nxt           = 1'b0;
        end else begin
          parity_nxt = 1'b1;
        end
        rc_nxt    = (rc_r == '1) ? rc_r : rc_r + RC_W'(1);
        quiet_nxt = '0;
        held_nxt  = 1'b0;
      end
    end

    if (cmd.quiet_step && (rc_r != '0)) begin
      quiet_nxt = quiet_inc;
    end

    if (cmd.run_step) begin
      ans_nxt = '0;
      if ((rc_r != '0) && (prod_r > PROD_W'(cfg.click_timeout_ms))) begin
        quiet_nxt             = '0;
        flags_nxt[EV_RUN_END] = 1'b1;
      end
    end

    if (cmd.query_ans) begin
      ans_nxt = '0;
      case (kind_r)
        QK_IDLE:  ans_nxt = ANS_W'(!held_r);
        QK_PRESS: begin
          ans_nxt               = ANS_W'(flags_r[EV_PRESSED]);
          flags_nxt[EV_PRESSED] = 1'b0;
        end
        QK_HELD:  ans_nxt = ANS_W'(held_r);
        QK_RELEASE: begin
          ans_nxt                = ANS_W'(flags_r[EV_RELEASED]);
          flags_nxt[EV_RELEASED] = 1'b0;
        end
        QK_CLICK: begin
          ans_nxt               = ANS_W'(flags_r[EV_CLICKED]);
          flags_nxt[EV_CLICKED] = 1'b0;
        end
        QK_DOUBLE: begin
          ans_nxt              = ANS_W'(flags_r[EV_DOUBLE]);
          flags_nxt[EV_DOUBLE] = 1'b0;
        end
        QK_REPEAT: begin
          if (flags_r[EV_RUN_END]) begin
            ans_nxt               = ANS_W'(rc_r);
            flags_nxt[EV_RUN_END] = 1'b0;
            rc_nxt                = '0;
          end
        end
        QK_HOLD_MS: begin
          ans_nxt = (prod_r[PROD_W-1:ANS_W] != '0) ? '1 : prod_r[ANS_W-1:0];
        end
        QK_SHOT: begin
          ans_nxt            = ANS_W'(flags_r[EV_SHOT]);
          flags_nxt[EV_SHOT] = 1'b0;
        end
        default: ans_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      kind_r <= in_tdata[QK_W:1];
    end
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.shot_mul) begin
      hms_r <= prod_r[HMS_W-1:0];
    end
    ans_r <= ans_nxt;
    if (cmd.publish) begin
      out_data_r <= ans_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      ln_r        <= 1'b0;
      lb_r        <= 1'b0;
      hold_r      <= '0;
      shot_r      <= '0;
      parity_r    <= 1'b0;
      rc_r        <= '0;
      quiet_r     <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      ln_r     <= ln_nxt;
      lb_r     <= lb_nxt;
      hold_r   <= hold_nxt;
      shot_r   <= shot_nxt;
      parity_r <= parity_nxt;
      rc_r     <= rc_nxt;
      quiet_r  <= quiet_nxt;
      flags_r  <= flags_nxt;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.held     = held_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

@@ rtl/button_event_detector.sv @@
// Top level of the button event detector: debounce, hold, shots, clicks, queries.
// A query item runs multiply and answer steps; a tick item runs hold, quiet and
// run steps, plus shot steps while held, around one shared 17x16 multiplier, then
// an output step. Items are taken only in idle; a waiting result in the output
// register holds the block only at its final step. Reset: synchronous active-low
// rst_n clears button state, counters, flags and out_tvalid and loads defaults.
module button_event_detector
  import bed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // [0] raw_level, [4:1] query_kind, [7:5] zero
  input  logic              in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ANS_W-1:0]  out_tdata,  // [15:0] answer
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bed_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_query  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bed_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
